@@ src/conv3x3_fixed_kernel_filter_unit_assert.svh @@
// Assertion macros for the 3x3 filter unit.
// Uses the clk and rst_n names of the including module; empty under SYNTHESIS.
`ifndef CONV3X3_FIXED_KERNEL_FILTER_UNIT_ASSERT_SVH
`define CONV3X3_FIXED_KERNEL_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define C3F_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error("c3f check failed");
`define C3F_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error("c3f check failed");
`define C3F_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("c3f check failed");
`else
`define C3F_ASSERT(lbl, expr)
`define C3F_ASSERT_IMPL(lbl, ante, cons)
`define C3F_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/c3f_pkg.sv @@
// Types and constants of the 3x3 fixed-kernel filter unit.
// No dependencies.
package c3f_pkg;

  localparam int IMG_WIDTH  = 32;
  localparam int IMG_HEIGHT = 32;
  localparam int COL_W      = $clog2(IMG_WIDTH);
  localparam int ROW_W      = $clog2(IMG_HEIGHT);

  localparam int SUM_W      = 15;     // kernel sum range -3952 .. 7523
  localparam int DIVISOR    = 13;
  localparam int CLIP_SUM   = 256 * DIVISOR;  // first sum whose quotient exceeds 255
  localparam int Q_IN_W     = 12;     // non-negative sums below CLIP_SUM
  localparam int DIV_SHIFT  = 16;
  localparam int DIV_MUL    = (2**DIV_SHIFT + DIVISOR - 1) / DIVISOR;  // ceil(2^16/13)
  localparam int DIV_MUL_W  = 13;
  localparam int PROD_W     = Q_IN_W + DIV_MUL_W;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } c3f_in_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic [4:0] out_row;
    logic [4:0] out_col;
    logic       frame_done;
  } c3f_out_t;

endpackage

@@ src/conv3x3_fixed_kernel_filter_unit.sv @@
// 3x3 fixed-kernel filter unit, top level.
// Depends on c3f_pkg and conv3x3_fixed_kernel_filter_unit_assert.svh.
//
// Usage
// - in_data carries one pixel per transfer in raster order; frame_start set on a
//   transfer restarts the row/column position at that pixel. The position also
//   wraps on its own after the last pixel of a frame.
// - Each pixel completes the 3x3 window centred one row up and one column left.
//   Interior centres give one transfer on out_data (value, centre row/column,
//   frame_done on the last interior centre); border centres give none.
// - A pixel's result reaches out_data through the memory read register, the
//   kernel sum register and the divide-and-clip register, in that order.
// - Throughput: one pixel per clock while out_ready is high. Each pixel does one
//   read and one write-back of the combined line-store memory at its column; the
//   write-back of a pixel overlaps the read of the next and is forwarded when both
//   hit the same column.
// - Reset clears the counters, window and all pipeline valids. The line store is
//   not cleared: no result uses an entry before two rows have refilled it.
// - If out_ready is low the held result stays put; the two inner stages keep
//   filling, so in_ready drops only once every stage holds an item.
`include "conv3x3_fixed_kernel_filter_unit_assert.svh"

module conv3x3_fixed_kernel_filter_unit
  import c3f_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  c3f_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output c3f_out_t out_data
);

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMG_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMG_HEIGHT - 1);
  localparam logic [COL_W-1:0] COL_ONE  = COL_W'(1);
  localparam logic [ROW_W-1:0] ROW_ONE  = ROW_W'(1);

  // item state carried through the memory-read stage
  typedef struct packed {
    logic [COL_W-1:0] addr;
    logic [7:0]       pixel;
    logic             interior;
    logic             done;
    logic [4:0]       row;
    logic [4:0]       col;
  } s1_meta_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [4:0]              row;
    logic [4:0]              col;
    logic                    done;
  } s2_meta_t;

  // position counters
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] r0;
  logic [COL_W-1:0] c0;
  logic [ROW_W-1:0] r0_m1;
  logic [COL_W-1:0] c0_m1;
  logic [ROW_W+4:0] row_ext;
  logic [COL_W+4:0] col_ext;

  // line store: {upper, middle} at each column
  logic [15:0] line_mem [IMG_WIDTH];
  logic [15:0] mem_q_r;
  logic        byp_v_r;
  logic [15:0] byp_d_r;
  logic [15:0] rd_word;
  logic [15:0] wr_word;

  logic [7:0] win_r [6];
  logic [7:0] top, mid, bot;

  logic     s1_v_r;
  s1_meta_t s1_r;
  s1_meta_t s1_nxt;
  logic     s2_v_r;
  s2_meta_t s2_r;
  logic     out_v_r;
  c3f_out_t out_r;

  logic in_fire, s1_go, s2_ready, out_free;
  logic signed [SUM_W-1:0] sum;
  logic [PROD_W-1:0]       prod;
  logic [7:0]              quot;

  // pipeline handshake
  assign out_free = !out_v_r || out_ready;
  assign s2_ready = !s2_v_r || out_free;
  assign s1_go    = s1_v_r && s2_ready;
  assign in_ready = !s1_v_r || s2_ready;
  assign in_fire  = in_valid && in_ready;

  // position of the arriving pixel
  assign r0    = in_data.frame_start ? '0 : row_r;
  assign c0    = in_data.frame_start ? '0 : col_r;
  assign r0_m1 = r0 - ROW_ONE;
  assign c0_m1 = c0 - COL_ONE;
  assign row_ext = {5'b0, r0_m1};
  assign col_ext = {5'b0, c0_m1};

  always_comb begin
    if (c0 == COL_LAST) begin
      col_nxt = '0;
      row_nxt = (r0 == ROW_LAST) ? '0 : r0 + ROW_ONE;
    end else begin
      col_nxt = c0 + COL_ONE;
      row_nxt = r0;
    end
  end

  always_comb begin
    s1_nxt.addr     = c0;
    s1_nxt.pixel    = in_data.pixel;
    s1_nxt.interior = (r0 >= ROW_W'(2)) && (c0 >= COL_W'(2));
    s1_nxt.done     = (r0 == ROW_LAST) && (c0 == COL_LAST);
    s1_nxt.row      = row_ext[4:0];
    s1_nxt.col      = col_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_fire) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // read at acceptance, write back when the item leaves stage 1
  assign rd_word = byp_v_r ? byp_d_r : mem_q_r;
  assign top     = rd_word[15:8];
  assign mid     = rd_word[7:0];
  assign bot     = s1_r.pixel;
  assign wr_word = {mid, s1_r.pixel};

  always_ff @(posedge clk) begin
    if (s1_go) begin
      line_mem[s1_r.addr] <= wr_word;
    end
    if (in_fire) begin
      mem_q_r <= line_mem[c0];
      byp_d_r <= wr_word;
    end
  end

  // forward the write-back when the next read hits the same column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_v_r <= 1'b0;
    end else if (in_fire) begin
      byp_v_r <= s1_go && (s1_r.addr == c0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  // window: [0..2] oldest column, [3..5] next; top, middle, bottom
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_go) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= bot;
    end
  end

  // kernel rows (-7,5,2), (-1,15,-1), (2,5,-7), plus rounding offset 128
  always_comb begin
    sum = SUM_W'(signed'(16'sd128))
        - SUM_W'(7)  * SUM_W'(win_r[0]) + SUM_W'(5)  * SUM_W'(win_r[3])
        + SUM_W'(2)  * SUM_W'(top)
        - SUM_W'(win_r[1])              + SUM_W'(15) * SUM_W'(win_r[4])
        - SUM_W'(mid)
        + SUM_W'(2)  * SUM_W'(win_r[2]) + SUM_W'(5)  * SUM_W'(win_r[5])
        - SUM_W'(7)  * SUM_W'(bot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_go && s1_r.interior;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_go) begin
      s2_r.sum  <= sum;
      s2_r.row  <= s1_r.row;
      s2_r.col  <= s1_r.col;
      s2_r.done <= s1_r.done;
    end
  end

  // divide by 13 by reciprocal; exact for 0 <= sum < 3328, the only sums whose
  // quotient is used. Negative sums clip to 0 and sums from 3328 up clip to 255.
  assign prod = PROD_W'(s2_r.sum[Q_IN_W-1:0]) * PROD_W'(DIV_MUL);

  always_comb begin
    priority if (s2_r.sum < 0) begin
      quot = 8'd0;
    end else if (s2_r.sum >= SUM_W'(CLIP_SUM)) begin
      quot = 8'd255;
    end else begin
      quot = prod[DIV_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_v_r) begin
      out_r.out_value  <= quot;
      out_r.out_row    <= s2_r.row;
      out_r.out_col    <= s2_r.col;
      out_r.frame_done <= s2_r.done;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `C3F_ASSERT(a_col_range, col_r <= COL_LAST)
  `C3F_ASSERT_NEXT(a_byp_set, in_fire && s1_go && (s1_r.addr == c0), byp_v_r)
  `C3F_ASSERT_NEXT(a_s2_hold, s2_v_r && !out_free, s2_v_r && $stable(s2_r))
  `C3F_ASSERT_IMPL(a_out_src, $rose(out_v_r), $past(s2_v_r))

endmodule
